// File: hw/rtl/pfcc_pkg.sv
// ----------------------------------------------------------------------------
// pfcc_pkg: shared definitions for the packet FIFO with checksum check
// Defaults for slot count and slot size, command codes, field widths and the
// sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pfcc_pkg;

   localparam int SLOTS_DEF     = 64;
   localparam int PKT_BYTES_DEF = 2048;

   localparam int BYTE_W = 8;
   localparam int CAP_W  = 12;
   localparam int LEN_W  = 12;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RD_LEN,
      ST_RD_DATA
   } state_type;

endpackage

`default_nettype wire

// File: hw/rtl/packet_fifo_with_checksum_check.sv
// ----------------------------------------------------------------------------
// packet_fifo_with_checksum_check: receive packet ring with checksum check
// Usage:
//   One request channel (req_*) carries transactions: a write appends one byte
//   to the packet being assembled, a read takes the next byte of the head
//   packet. Every request transaction yields exactly one response transaction
//   on rsp_*. Both channels use valid/stall.
//   Packets live in SLOTS slots of PKT_BYTES bytes in one RAM; lengths in a
//   second RAM. One slot stays empty, so SLOTS-1 packets may wait.
//   A write or a read of an empty ring answers in the cycle after it is taken.
//   A read of a later byte answers from ST_RD_DATA after the packet RAM read;
//   the first read of a packet passes ST_RD_LEN (length RAM), then ST_RD_DATA
//   (packet RAM), or answers from ST_RD_LEN with all fields zero when its
//   capacity is zero. A write transaction is taken every cycle while responses
//   drain; a read keeps the block busy until its response is registered.
//   Reset clears pointers, counters and the response valid bit; the RAMs need
//   no clearing, so the block is ready in the first cycle after reset.
//   While rsp_stall holds a response, req_stall stays high and no request is
//   taken; with the response register empty one request is still taken.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_fifo_with_checksum_check #(
   parameter int SLOTS     = pfcc_pkg::SLOTS_DEF,
   parameter int PKT_BYTES = pfcc_pkg::PKT_BYTES_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,

   input  wire logic                        req_valid,
   output      logic                        req_stall,
   input  wire logic                        req_cmd,
   input  wire logic [pfcc_pkg::BYTE_W-1:0] req_wr_byte,
   input  wire logic                        req_wr_last,
   input  wire logic [pfcc_pkg::CAP_W-1:0]  req_rd_cap,

   output      logic                        rsp_valid,
   input  wire logic                        rsp_stall,
   output      logic                        rsp_rd_valid,
   output      logic [pfcc_pkg::BYTE_W-1:0] rsp_rd_byte,
   output      logic                        rsp_rd_last,
   output      logic [pfcc_pkg::LEN_W-1:0]  rsp_rd_len,
   output      logic                        rsp_sum_ok,
   output      logic                        rsp_queue_empty,
   output      logic                        rsp_wr_dropped
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(PKT_BYTES + 1);
   localparam int DEPTH  = SLOTS * PKT_BYTES;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int LIM_W  = (CNT_W > pfcc_pkg::CAP_W) ? CNT_W : pfcc_pkg::CAP_W;
   localparam logic [ADDR_W-1:0] SLOT_SIZE = ADDR_W'(PKT_BYTES);
   localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(PKT_BYTES);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS - 1);

   pfcc_pkg::state_type state_ff, state_in;

   logic [SLOT_W-1:0]           head_ff, head_in;
   logic [SLOT_W-1:0]           tail_ff, tail_in;
   logic [CNT_W-1:0]            wr_cnt_ff, wr_cnt_in;
   logic [CNT_W-1:0]            rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0]            rd_lim_ff, rd_lim_in;
   logic [pfcc_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [pfcc_pkg::BYTE_W-1:0] check_ff, check_in;
   logic [pfcc_pkg::CAP_W-1:0]  cap_ff, cap_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_rd_valid_ff, rsp_rd_valid_in;
   logic [pfcc_pkg::BYTE_W-1:0] rsp_rd_byte_ff, rsp_rd_byte_in;
   logic                        rsp_rd_last_ff, rsp_rd_last_in;
   logic [pfcc_pkg::LEN_W-1:0]  rsp_rd_len_ff, rsp_rd_len_in;
   logic                        rsp_sum_ok_ff, rsp_sum_ok_in;
   logic                        rsp_queue_empty_ff, rsp_queue_empty_in;
   logic                        rsp_wr_dropped_ff, rsp_wr_dropped_in;

   logic                        out_free;
   logic                        accept;

   logic                        pkt_we;
   logic                        pkt_re;
   logic [ADDR_W-1:0]           pkt_wr_addr;
   logic [ADDR_W-1:0]           pkt_rd_addr;
   logic [pfcc_pkg::BYTE_W-1:0] pkt_rd_data;
   logic                        len_we;
   logic                        len_re;
   logic [CNT_W-1:0]            len_wr_data;
   logic [CNT_W-1:0]            len_rd_data;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == pfcc_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign pkt_wr_addr = ADDR_W'(tail_ff) * SLOT_SIZE + ADDR_W'(wr_cnt_ff);
   assign pkt_rd_addr = ADDR_W'(head_ff) * SLOT_SIZE + ADDR_W'(rd_cnt_ff);

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (s == SLOT_LAST) ? '0 : s + SLOT_W'(1);
   endfunction

   pfcc_ram #(
      .WIDTH (pfcc_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_pkt_ram (
      .clock   (clock),
      .wr_en   (pkt_we),
      .wr_addr (pkt_wr_addr),
      .wr_data (req_wr_byte),
      .rd_en   (pkt_re),
      .rd_addr (pkt_rd_addr),
      .rd_data (pkt_rd_data)
   );

   pfcc_ram #(
      .WIDTH (CNT_W),
      .DEPTH (SLOTS)
   ) u_len_ram (
      .clock   (clock),
      .wr_en   (len_we),
      .wr_addr (tail_ff),
      .wr_data (len_wr_data),
      .rd_en   (len_re),
      .rd_addr (head_ff),
      .rd_data (len_rd_data)
   );

   always_comb begin
      logic                        dropped;
      logic [CNT_W-1:0]            wr_cnt_next;
      logic [CNT_W-1:0]            rd_cnt_next;
      logic [LIM_W-1:0]            len_wide;
      logic [LIM_W-1:0]            cap_wide;
      logic [LIM_W-1:0]            lim_wide;
      logic [LIM_W-1:0]            lim_out;
      logic [CNT_W-1:0]            lim;
      logic [pfcc_pkg::BYTE_W-1:0] sum_next;
      logic                        last;

      state_in  = state_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      wr_cnt_in = wr_cnt_ff;
      rd_cnt_in = rd_cnt_ff;
      rd_lim_in = rd_lim_ff;
      sum_in    = sum_ff;
      check_in  = check_ff;
      cap_in    = cap_ff;

      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_rd_valid_in    = rsp_rd_valid_ff;
      rsp_rd_byte_in     = rsp_rd_byte_ff;
      rsp_rd_last_in     = rsp_rd_last_ff;
      rsp_rd_len_in      = rsp_rd_len_ff;
      rsp_sum_ok_in      = rsp_sum_ok_ff;
      rsp_queue_empty_in = rsp_queue_empty_ff;
      rsp_wr_dropped_in  = rsp_wr_dropped_ff;

      pkt_we      = 1'b0;
      pkt_re      = 1'b0;
      len_we      = 1'b0;
      len_re      = 1'b0;
      dropped     = 1'b0;
      wr_cnt_next = wr_cnt_ff + CNT_W'(1);
      len_wr_data = wr_cnt_next;
      rd_cnt_next = rd_cnt_ff + CNT_W'(1);
      len_wide    = LIM_W'(len_rd_data);
      cap_wide    = LIM_W'(cap_ff);
      lim_wide    = (len_wide < cap_wide) ? len_wide : cap_wide;
      lim         = CNT_W'(lim_wide);
      lim_out     = LIM_W'(rd_lim_ff);
      sum_next    = sum_ff + pkt_rd_data;
      last        = 1'b0;

      case (state_ff)
         pfcc_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in       = 1'b1;
               rsp_rd_valid_in    = 1'b0;
               rsp_rd_byte_in     = '0;
               rsp_rd_last_in     = 1'b0;
               rsp_rd_len_in      = '0;
               rsp_sum_ok_in      = 1'b0;
               rsp_queue_empty_in = 1'b0;
               rsp_wr_dropped_in  = 1'b0;
               if (req_cmd == pfcc_pkg::CMD_WRITE) begin
                  if (wr_cnt_ff < CNT_MAX) begin
                     pkt_we    = 1'b1;
                     wr_cnt_in = wr_cnt_next;
                  end else begin
                     dropped     = 1'b1;
                     len_wr_data = wr_cnt_ff;
                  end
                  if (req_wr_last) begin
                     if (next_slot(tail_ff) == head_ff) begin
                        dropped = 1'b1;
                     end else begin
                        len_we  = 1'b1;
                        tail_in = next_slot(tail_ff);
                     end
                     wr_cnt_in = '0;
                  end
                  rsp_wr_dropped_in = dropped;
               end else if (head_ff == tail_ff) begin
                  rsp_queue_empty_in = 1'b1;
               end else begin
                  rsp_valid_in = 1'b0;
                  cap_in       = req_rd_cap;
                  if (rd_cnt_ff == '0) begin
                     len_re   = 1'b1;
                     state_in = pfcc_pkg::ST_RD_LEN;
                  end else begin
                     pkt_re   = 1'b1;
                     state_in = pfcc_pkg::ST_RD_DATA;
                  end
               end
            end
         end

         pfcc_pkg::ST_RD_LEN: begin
            if (cap_ff == '0) begin
               rsp_valid_in = 1'b1;
               state_in     = pfcc_pkg::ST_IDLE;
            end else begin
               rd_lim_in = (lim == '0) ? CNT_W'(1) : lim;
               pkt_re    = 1'b1;
               state_in  = pfcc_pkg::ST_RD_DATA;
            end
         end

         pfcc_pkg::ST_RD_DATA: begin
            rsp_valid_in    = 1'b1;
            rsp_rd_valid_in = 1'b1;
            if (rd_cnt_ff == '0) begin
               check_in       = pkt_rd_data;
               sum_next       = '0;
               rsp_rd_byte_in = '0;
               last           = (rd_cnt_next >= rd_lim_ff);
               rsp_sum_ok_in  = last && (pkt_rd_data == '0);
            end else begin
               rsp_rd_byte_in = pkt_rd_data;
               last           = (rd_cnt_next >= rd_lim_ff);
               rsp_sum_ok_in  = last && (sum_next == check_ff);
            end
            sum_in         = sum_next;
            rsp_rd_last_in = last;
            if (last) begin
               rsp_rd_len_in = lim_out[pfcc_pkg::LEN_W-1:0];
               head_in       = next_slot(head_ff);
               rd_cnt_in     = '0;
            end else begin
               rsp_rd_len_in = '0;
               rd_cnt_in     = rd_cnt_next;
            end
            state_in = pfcc_pkg::ST_IDLE;
         end

         default: begin
            state_in = pfcc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfcc_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         wr_cnt_ff    <= '0;
         rd_cnt_ff    <= '0;
         rd_lim_ff    <= '0;
         sum_ff       <= '0;
         check_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         wr_cnt_ff    <= wr_cnt_in;
         rd_cnt_ff    <= rd_cnt_in;
         rd_lim_ff    <= rd_lim_in;
         sum_ff       <= sum_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cap_ff             <= cap_in;
      rsp_rd_valid_ff    <= rsp_rd_valid_in;
      rsp_rd_byte_ff     <= rsp_rd_byte_in;
      rsp_rd_last_ff     <= rsp_rd_last_in;
      rsp_rd_len_ff      <= rsp_rd_len_in;
      rsp_sum_ok_ff      <= rsp_sum_ok_in;
      rsp_queue_empty_ff <= rsp_queue_empty_in;
      rsp_wr_dropped_ff  <= rsp_wr_dropped_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_rd_valid    = rsp_rd_valid_ff;
   assign rsp_rd_byte     = rsp_rd_byte_ff;
   assign rsp_rd_last     = rsp_rd_last_ff;
   assign rsp_rd_len      = rsp_rd_len_ff;
   assign rsp_sum_ok      = rsp_sum_ok_ff;
   assign rsp_queue_empty = rsp_queue_empty_ff;
   assign rsp_wr_dropped  = rsp_wr_dropped_ff;

endmodule

`default_nettype wire

// File: hw/rtl/pfcc_ram.sv
// ----------------------------------------------------------------------------
// pfcc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pfcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// File: tb/packet_ring_checker.sv
// ----------------------------------------------------------------------------
// packet_ring_checker: response predictor and comparator for the packet ring
// Observes both channels of the packet FIFO. Every accepted request updates a
// private model of the ring (slot store, lengths, head/tail, read progress and
// checksum) and queues the response it must cause. Every accepted response is
// compared field by field against the oldest queued one. Reports the mismatch
// total and the number of responses still owed.
// ----------------------------------------------------------------------------
module packet_ring_checker
   import pfcc_pkg::*;
#(
   parameter int SLOTS     = SLOTS_DEF,
   parameter int PKT_BYTES = PKT_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic              req_cmd,
   input  logic [BYTE_W-1:0] req_wr_byte,
   input  logic              req_wr_last,
   input  logic [CAP_W-1:0]  req_rd_cap,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_rd_valid,
   input  logic [BYTE_W-1:0] rsp_rd_byte,
   input  logic              rsp_rd_last,
   input  logic [LEN_W-1:0]  rsp_rd_len,
   input  logic              rsp_sum_ok,
   input  logic              rsp_queue_empty,
   input  logic              rsp_wr_dropped,
   output int                fail_count,
   output int                outstanding
);

   typedef struct packed {
      logic              rd_valid;
      logic [BYTE_W-1:0] rd_byte;
      logic              rd_last;
      logic [LEN_W-1:0]  rd_len;
      logic              sum_ok;
      logic              queue_empty;
      logic              wr_dropped;
   } ring_rsp_t;

   logic [BYTE_W-1:0] ring_bytes [SLOTS*PKT_BYTES];
   int                slot_len [SLOTS];
   int                head_slot;
   int                tail_slot;
   int                fill_count;
   int                drain_count;
   int                drain_limit;
   logic [BYTE_W-1:0] byte_sum;
   logic [BYTE_W-1:0] check_byte;

   ring_rsp_t         expected_rsp_q [$];
   ring_rsp_t         got_rsp;
   ring_rsp_t         want_rsp;
   int                mismatch_total = 0;
   int                rsp_index = 0;

   assign fail_count = mismatch_total;

   function automatic int next_slot(input int s);
      return (s + 1 >= SLOTS) ? 0 : s + 1;
   endfunction

   function automatic ring_rsp_t predict_ring_step(input logic cmd,
                                                   input logic [BYTE_W-1:0] data,
                                                   input logic is_last,
                                                   input logic [CAP_W-1:0] cap);
      ring_rsp_t         r;
      logic [BYTE_W-1:0] b;
      r = '0;
      if (cmd == CMD_WRITE) begin
         if (fill_count < PKT_BYTES) begin
            ring_bytes[tail_slot*PKT_BYTES + fill_count] = data;
            fill_count++;
         end else begin
            r.wr_dropped = 1'b1;
         end
         if (is_last) begin
            if (next_slot(tail_slot) == head_slot) begin
               r.wr_dropped = 1'b1;
            end else begin
               slot_len[tail_slot] = fill_count;
               tail_slot = next_slot(tail_slot);
            end
            fill_count = 0;
         end
      end else if (head_slot == tail_slot) begin
         r.queue_empty = 1'b1;
      end else if (drain_count != 0 || cap != 0) begin
         if (drain_count == 0) begin
            drain_limit = (slot_len[head_slot] < int'(cap)) ? slot_len[head_slot] : int'(cap);
            if (drain_limit == 0) drain_limit = 1;
         end
         b = ring_bytes[head_slot*PKT_BYTES + drain_count];
         if (drain_count == 0) begin
            check_byte = b;
            byte_sum   = '0;
         end else begin
            byte_sum  = byte_sum + b;
            r.rd_byte = b;
         end
         r.rd_valid = 1'b1;
         drain_count++;
         if (drain_count >= drain_limit) begin
            r.rd_last = 1'b1;
            r.rd_len  = LEN_W'(drain_limit);
            r.sum_ok  = (byte_sum == check_byte);
            head_slot   = next_slot(head_slot);
            drain_count = 0;
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatch_total < 50) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatch_total++;
   endtask

   task automatic compare_field(input string name, input int unsigned got_v,
                                input int unsigned want_v);
      if (got_v != want_v)
         report_mismatch($sformatf("response %0d field %s got %0d expected %0d",
                                   rsp_index, name, got_v, want_v));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         head_slot   = 0;
         tail_slot   = 0;
         fill_count  = 0;
         drain_count = 0;
         drain_limit = 0;
         byte_sum    = '0;
         check_byte  = '0;
         expected_rsp_q.delete();
         outstanding <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got_rsp = '{rsp_rd_valid, rsp_rd_byte, rsp_rd_last, rsp_rd_len,
                        rsp_sum_ok, rsp_queue_empty, rsp_wr_dropped};
            if (expected_rsp_q.size() == 0) begin
               report_mismatch($sformatf("response %0d arrived with no transaction pending",
                                         rsp_index));
            end else begin
               want_rsp = expected_rsp_q.pop_front();
               compare_field("rd_valid", got_rsp.rd_valid, want_rsp.rd_valid);
               compare_field("rd_byte", got_rsp.rd_byte, want_rsp.rd_byte);
               compare_field("rd_last", got_rsp.rd_last, want_rsp.rd_last);
               compare_field("rd_len", got_rsp.rd_len, want_rsp.rd_len);
               compare_field("sum_ok", got_rsp.sum_ok, want_rsp.sum_ok);
               compare_field("queue_empty", got_rsp.queue_empty, want_rsp.queue_empty);
               compare_field("wr_dropped", got_rsp.wr_dropped, want_rsp.wr_dropped);
            end
            rsp_index++;
         end
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(predict_ring_step(req_cmd, req_wr_byte,
                                                       req_wr_last, req_rd_cap));
         outstanding <= expected_rsp_q.size();
      end
   end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the packet FIFO with checksum check
// Drives write and read transactions into the ring: a directed pass over the
// special cases, a pass that fills the ring past capacity under a long
// response hold-off, one overlength packet, then random packets with reads
// interleaved. Both channels idle at random. The checker beside the block
// predicts and compares; a watchdog ends a run that stops making progress.
// ----------------------------------------------------------------------------
module tb_top;
   import pfcc_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 150;
   localparam int RANDOM_ITEMS = 850;

   typedef logic [BYTE_W-1:0] byte_q_t [$];

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic              req_cmd;
   logic [BYTE_W-1:0] req_wr_byte;
   logic              req_wr_last;
   logic [CAP_W-1:0]  req_rd_cap;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_rd_valid;
   logic [BYTE_W-1:0] rsp_rd_byte;
   logic              rsp_rd_last;
   logic [LEN_W-1:0]  rsp_rd_len;
   logic              rsp_sum_ok;
   logic              rsp_queue_empty;
   logic              rsp_wr_dropped;
   int                fail_count;
   int                outstanding;

   bit                no_gaps;
   bit                hold_rsp;
   int                items_sent;
   int                pkt_len_q [$];

   packet_fifo_with_checksum_check u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_wr_byte     (req_wr_byte),
      .req_wr_last     (req_wr_last),
      .req_rd_cap      (req_rd_cap),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_rd_valid    (rsp_rd_valid),
      .rsp_rd_byte     (rsp_rd_byte),
      .rsp_rd_last     (rsp_rd_last),
      .rsp_rd_len      (rsp_rd_len),
      .rsp_sum_ok      (rsp_sum_ok),
      .rsp_queue_empty (rsp_queue_empty),
      .rsp_wr_dropped  (rsp_wr_dropped)
   );

   packet_ring_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic send_txn(input logic cmd, input logic [BYTE_W-1:0] data,
                           input logic is_last, input logic [CAP_W-1:0] cap);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_wr_byte <= data;
      req_wr_last <= is_last;
      req_rd_cap  <= cap;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_write(input logic [BYTE_W-1:0] data, input logic is_last);
      send_txn(CMD_WRITE, data, is_last, CAP_W'($urandom_range(0, 4095)));
   endtask

   task automatic send_read(input logic [CAP_W-1:0] cap);
      send_txn(CMD_READ, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), cap);
   endtask

   task automatic send_packet(input byte_q_t pkt);
      int i;
      for (i = 0; i < pkt.size(); i++) send_write(pkt[i], i == pkt.size() - 1);
   endtask

   // hold until every owed response has been taken
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   function automatic byte_q_t make_packet(input int len, input bit good_sum);
      byte_q_t           pkt;
      logic [BYTE_W-1:0] total;
      int                i;
      total = '0;
      pkt.push_back('0);
      for (i = 1; i < len; i++) begin
         pkt.push_back(BYTE_W'($urandom_range(0, 255)));
         total = total + pkt[i];
      end
      pkt[0] = good_sum ? total : BYTE_W'($urandom_range(0, 255));
      return pkt;
   endfunction

   // receiver: random stall before each response, plus one long hold-off on request
   initial begin
      int n;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end
         n = no_gaps ? 0 : $urandom_range(0, 3);
         if (n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      int idle;
      idle = 0;
      wait (reset === 1'b0);
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
         else idle++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      byte_q_t          pkt;
      int               i;
      int               len;
      int               head_len;
      int               reads;
      int               wi;
      int               ri;
      int               random_start;
      logic [CAP_W-1:0] cap;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_cmd     = CMD_WRITE;
      req_wr_byte = '0;
      req_wr_last = 1'b0;
      req_rd_cap  = '0;
      no_gaps     = 1'b1;
      hold_rsp    = 1'b0;
      items_sent  = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ring, single-byte packets, zero capacity, truncation
      send_read(12'd1);
      send_write(8'h00, 1'b1);
      send_read(12'd1);
      send_write(8'hFF, 1'b1);
      send_read(12'hFFF);
      send_write(8'h80, 1'b0);
      send_write(8'hFF, 1'b0);
      send_write(8'h80, 1'b0);
      send_write(8'h01, 1'b1);
      send_read(12'd0);
      send_read(12'h800);
      send_read(12'd0);
      send_read(12'd1);
      send_read(12'd0);
      send_write(8'h12, 1'b0);
      send_write(8'h34, 1'b0);
      send_write(8'h56, 1'b0);
      send_write(8'h78, 1'b1);
      send_read(12'd2);
      send_read(12'd2);
      send_read(12'd3);
      wait_drained();

      // fill the ring past capacity while responses are held off
      no_gaps  = 1'b0;
      hold_rsp = 1'b1;
      for (i = 0; i < SLOTS_DEF; i++) begin
         len = $urandom_range(1, 3);
         send_packet(make_packet(len, $urandom_range(0, 1)));
         if (i < SLOTS_DEF - 1) pkt_len_q.push_back(len);
      end
      wait_drained();
      while (pkt_len_q.size() != 0) begin
         head_len = pkt_len_q.pop_front();
         send_read(CAP_W'($urandom_range(head_len, 4095)));
         for (i = 1; i < head_len; i++) send_read(CAP_W'($urandom_range(0, 4095)));
      end
      send_read(CAP_W'($urandom_range(0, 4095)));

      // overlength packet: trailing bytes dropped, first PKT_BYTES_DEF kept
      send_packet(make_packet(PKT_BYTES_DEF + 2, 1'b1));
      send_read(CAP_W'($urandom_range(PKT_BYTES_DEF, 4095)));
      for (i = 1; i < PKT_BYTES_DEF; i++) send_read(CAP_W'($urandom_range(0, 4095)));
      wait_drained();

      // random packets with reads of the oldest packet interleaved
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 7) == 0) no_gaps = !no_gaps;
         if ($urandom_range(0, 49) == 0) wait_drained();
         if (pkt_len_q.size() == 0 && $urandom_range(0, 2) == 0)
            send_read(CAP_W'($urandom_range(0, 4095)));
         len   = ($urandom_range(0, 29) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
         pkt   = make_packet(len, $urandom_range(0, 3) != 0);
         reads = 0;
         if (pkt_len_q.size() != 0 && $urandom_range(0, 4) != 0) begin
            head_len = pkt_len_q.pop_front();
            if ($urandom_range(0, 3) == 0) cap = CAP_W'($urandom_range(1, 4095));
            else cap = CAP_W'($urandom_range(1, head_len + 2));
            reads = (head_len < int'(cap)) ? head_len : int'(cap);
            if ($urandom_range(0, 9) == 0) send_read(12'd0);
         end
         pkt_len_q.push_back(len);
         wi = 0;
         ri = 0;
         while (wi < len || ri < reads) begin
            if (ri < reads && (wi == len || $urandom_range(0, 1) == 1)) begin
               send_read((ri == 0) ? cap : CAP_W'($urandom_range(0, 4095)));
               ri++;
            end else begin
               send_write(pkt[wi], wi == len - 1);
               wi++;
            end
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
